FILE: src/bsc_pkg.sv
// shared types and constants for the banker's safety check block
package bsc_pkg;

  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;
  localparam int FIELD_W = 16;
  localparam int OPCODE_W = 2;

  localparam logic [OPCODE_W-1:0] OP_LOAD_CLAIM = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_TOTAL = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHECK = 2'd2;

  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_ADD,
    ALU_FIT
  } alu_op_t;

endpackage

FILE: src/bsc_item_if.sv
// input channel carrying load and check transactions
interface bsc_item_if;
  logic                              valid;
  logic                              ready;
  logic [bsc_pkg::OPCODE_W-1:0]      opcode;
  logic [bsc_pkg::INDEX_W-1:0]       proc_index;
  logic [bsc_pkg::INDEX_W-1:0]       res_index;
  logic [bsc_pkg::FIELD_W-1:0]       max_value;
  logic [bsc_pkg::FIELD_W-1:0]       alloc_value;
  logic [bsc_pkg::FIELD_W-1:0]       total_value;

  modport source (
    output valid, opcode, proc_index, res_index, max_value, alloc_value, total_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, proc_index, res_index, max_value, alloc_value, total_value,
    output ready
  );
endinterface

FILE: src/bsc_result_if.sv
// result channel carrying the safety check outcome
interface bsc_result_if;
  logic                         valid;
  logic                         ready;
  logic                         deadlock;
  logic [bsc_pkg::COUNT_W-1:0]  finished_count;

  modport source (
    output valid, deadlock, finished_count,
    input  ready
  );
  modport sink (
    input  valid, deadlock, finished_count,
    output ready
  );
endinterface

FILE: src/bsc_alu.sv
// shared add, subtract and need-fit compare unit
module bsc_alu #(
  parameter int VALUE_BITS = 16,
  parameter int AW = 22
) (
  input  bsc_pkg::alu_op_t        op,
  input  logic signed [AW-1:0]    base,
  input  logic [VALUE_BITS-1:0]   claim,
  input  logic [VALUE_BITS-1:0]   alloc,
  output logic signed [AW-1:0]    sum,
  output logic                    neg
);

  logic signed [AW-1:0] alloc_ext;
  logic signed [AW-1:0] claim_ext;

  assign alloc_ext = $signed({{(AW-VALUE_BITS){1'b0}}, alloc});
  assign claim_ext = $signed({{(AW-VALUE_BITS){1'b0}}, claim});

  // fit: avail + alloc - claim >= 0 means need fits
  always_comb begin
    case (op)
      bsc_pkg::ALU_SUB: sum = base - alloc_ext;
      bsc_pkg::ALU_ADD: sum = base + alloc_ext;
      bsc_pkg::ALU_FIT: sum = base + alloc_ext - claim_ext;
      default:          sum = base;
    endcase
  end

  assign neg = sum[AW-1];

endmodule

FILE: src/bsc_seq.sv
// sequencer, matrix and vector memories for the safety check
module bsc_seq #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_RES = 16,
  parameter int VALUE_BITS = 16,
  localparam int CW = $clog2(MAX_PROCS + 1),
  localparam int RCW = $clog2(MAX_RES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [CW-1:0]  np,
  input  logic [RCW-1:0] nr,
  bsc_item_if.sink       item,
  bsc_result_if.source   result
);

  localparam int PB = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RB = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int AW = VALUE_BITS + $clog2(MAX_PROCS + 1) + 1;
  localparam int MDEPTH = MAX_PROCS * (1 << RB);
  localparam int AB = PB + RB;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AV_RD,
    S_AV_EX,
    S_SEL,
    S_CK_RD,
    S_CK_EX,
    S_RL_RD,
    S_RL_EX,
    S_FIN
  } state_t;

  state_t state;

  logic [2*VALUE_BITS-1:0] mat_mem [MDEPTH];
  logic [VALUE_BITS-1:0]   tot_mem [MAX_RES];
  logic signed [AW-1:0]    av_mem [MAX_RES];

  logic [2*VALUE_BITS-1:0] mat_q;
  logic [VALUE_BITS-1:0]   tot_q;
  logic signed [AW-1:0]    av_q;

  logic [CW-1:0]           pi;
  logic [RCW-1:0]          rj;
  logic [CW-1:0]           finished;
  logic                    progress;
  logic [MAX_PROCS-1:0]    done;
  logic signed [AW-1:0]    acc;

  logic                    accept;
  logic                    proc_ok;
  logic                    res_ok;
  logic                    mat_we;
  logic                    tot_we;
  logic                    av_we;
  logic [AB-1:0]           mat_wa;
  logic [AB-1:0]           mat_ra;
  logic [VALUE_BITS-1:0]   max_v;
  logic [VALUE_BITS-1:0]   alloc_v;
  logic [VALUE_BITS-1:0]   total_v;
  logic [31:0]             max_ext;
  logic [31:0]             alloc_ext;
  logic [31:0]             total_ext;
  logic [CW-1:0]           pi_inc;
  logic [RCW-1:0]          rj_inc;
  logic                    last_p;
  logic                    last_r;

  bsc_pkg::alu_op_t        alu_op;
  logic signed [AW-1:0]    alu_base;
  logic signed [AW-1:0]    alu_sum;
  logic                    alu_neg;

  assign accept = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);

  assign proc_ok = 32'(item.proc_index) < MAX_PROCS;
  assign res_ok = 32'(item.res_index) < MAX_RES;

  assign max_ext = 32'(item.max_value);
  assign alloc_ext = 32'(item.alloc_value);
  assign total_ext = 32'(item.total_value);
  assign max_v = max_ext[VALUE_BITS-1:0];
  assign alloc_v = alloc_ext[VALUE_BITS-1:0];
  assign total_v = total_ext[VALUE_BITS-1:0];

  assign mat_we = accept && item.opcode == bsc_pkg::OP_LOAD_CLAIM && proc_ok && res_ok;
  assign tot_we = accept && item.opcode == bsc_pkg::OP_LOAD_TOTAL && res_ok;
  assign mat_wa = {PB'(item.proc_index), RB'(item.res_index)};
  assign mat_ra = {pi[PB-1:0], rj[RB-1:0]};

  assign pi_inc = CW'(pi + 1'b1);
  assign rj_inc = RCW'(rj + 1'b1);
  assign last_p = (pi_inc == np);
  assign last_r = (rj_inc == nr);

  always_comb begin
    case (state)
      S_AV_EX: alu_op = bsc_pkg::ALU_SUB;
      S_RL_EX: alu_op = bsc_pkg::ALU_ADD;
      default: alu_op = bsc_pkg::ALU_FIT;
    endcase
  end

  assign alu_base = (state == S_AV_EX)
                  ? ((pi == '0) ? $signed({{(AW-VALUE_BITS){1'b0}}, tot_q}) : acc)
                  : av_q;

  assign av_we = (state == S_AV_EX && last_p) || state == S_RL_EX;

  bsc_alu #(
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_alu (
    .op    (alu_op),
    .base  (alu_base),
    .claim (mat_q[2*VALUE_BITS-1:VALUE_BITS]),
    .alloc (mat_q[VALUE_BITS-1:0]),
    .sum   (alu_sum),
    .neg   (alu_neg)
  );

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= {max_v, alloc_v};
    end
    mat_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[RB'(item.res_index)] <= total_v;
    end
    tot_q <= tot_mem[rj[RB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (av_we) begin
      av_mem[rj[RB-1:0]] <= alu_sum;
    end
    av_q <= av_mem[rj[RB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pi <= '0;
      rj <= '0;
      finished <= '0;
      progress <= 1'b0;
      done <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_FIN) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && item.opcode == bsc_pkg::OP_CHECK) begin
            pi <= '0;
            rj <= '0;
            finished <= '0;
            progress <= 1'b0;
            done <= '0;
            if (np == '0) begin
              state <= S_FIN;
            end else if (nr == '0) begin
              state <= S_SEL;
            end else begin
              state <= S_AV_RD;
            end
          end
        end
        S_AV_RD: begin
          state <= S_AV_EX;
        end
        S_AV_EX: begin
          if (last_p) begin
            pi <= '0;
            if (last_r) begin
              rj <= '0;
              state <= S_SEL;
            end else begin
              rj <= rj_inc;
              state <= S_AV_RD;
            end
          end else begin
            acc <= alu_sum;
            pi <= pi_inc;
            state <= S_AV_RD;
          end
        end
        S_SEL: begin
          if (pi == np) begin
            if (finished == np || !progress) begin
              state <= S_FIN;
            end else begin
              pi <= '0;
              progress <= 1'b0;
            end
          end else if (done[pi[PB-1:0]]) begin
            pi <= pi_inc;
          end else if (nr == '0) begin
            done[pi[PB-1:0]] <= 1'b1;
            finished <= CW'(finished + 1'b1);
            progress <= 1'b1;
            pi <= pi_inc;
          end else begin
            rj <= '0;
            state <= S_CK_RD;
          end
        end
        S_CK_RD: begin
          state <= S_CK_EX;
        end
        S_CK_EX: begin
          if (alu_neg) begin
            pi <= pi_inc;
            state <= S_SEL;
          end else if (last_r) begin
            rj <= '0;
            state <= S_RL_RD;
          end else begin
            rj <= rj_inc;
            state <= S_CK_RD;
          end
        end
        S_RL_RD: begin
          state <= S_RL_EX;
        end
        S_RL_EX: begin
          if (last_r) begin
            done[pi[PB-1:0]] <= 1'b1;
            finished <= CW'(finished + 1'b1);
            progress <= 1'b1;
            pi <= pi_inc;
            rj <= '0;
            state <= S_SEL;
          end else begin
            rj <= rj_inc;
            state <= S_RL_RD;
          end
        end
        S_FIN: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            result.deadlock <= (finished < np);
            result.finished_count <= bsc_pkg::COUNT_W'(finished);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/bankers_safety_check_core.sv
// banker's safety check: load transactions are accepted one per cycle while no check is in progress
// a check walks P processes by R resources through one shared add/compare unit
// a check makes at most P passes over the processes
// the result also waits while an earlier result is not taken
// each memory access goes through a read state and then an execute state; no new item meanwhile
// synchronous reset clears control state and sets proc_count and res_count to 1
module bankers_safety_check_core #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_RES = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  bsc_item_if.sink      item,
  bsc_result_if.source  result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int RCW = $clog2(MAX_RES + 1);

  logic [bsc_pkg::COUNT_W-1:0] proc_count;
  logic [bsc_pkg::COUNT_W-1:0] res_count;
  logic [CW-1:0]               np;
  logic [RCW-1:0]              nr;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= bsc_pkg::COUNT_W'(1);
      res_count <= bsc_pkg::COUNT_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        bsc_pkg::REG_PROC_COUNT: proc_count <= pwdata[bsc_pkg::COUNT_W-1:0];
        bsc_pkg::REG_RES_COUNT:  res_count <= pwdata[bsc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bsc_pkg::REG_PROC_COUNT: prdata = 32'(proc_count);
      bsc_pkg::REG_RES_COUNT:  prdata = 32'(res_count);
      default:                 prdata = '0;
    endcase
  end

  assign np = (32'(proc_count) > MAX_PROCS) ? CW'(MAX_PROCS) : CW'(proc_count);
  assign nr = (32'(res_count) > MAX_RES) ? RCW'(MAX_RES) : RCW'(res_count);

  bsc_seq #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_RES    (MAX_RES),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .np     (np),
    .nr     (nr),
    .item   (item),
    .result (result)
  );

  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.opcode == bsc_pkg::OP_CHECK |=> !item.ready)
    else $error("check transaction did not stall the input");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> 32'(result.finished_count) <= 32'(np))
    else $error("finished count above process count");

  a_deadlock_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.deadlock == (32'(result.finished_count) < 32'(np)))
    else $error("deadlock flag disagrees with finished count");

endmodule

FILE: dv/bankers_safety_check_core_tb.sv
// testbench for the banker's safety check core: directed, back-pressure, full-size and random runs
`timescale 1ns / 100ps

module bankers_safety_check_core_tb;

  localparam int N_PROCS = 16;
  localparam int N_RES = 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 950;
  localparam logic [bsc_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [bsc_pkg::OPCODE_W-1:0] opcode;
    logic [bsc_pkg::INDEX_W-1:0]  proc_index;
    logic [bsc_pkg::INDEX_W-1:0]  res_index;
    logic [bsc_pkg::FIELD_W-1:0]  max_value;
    logic [bsc_pkg::FIELD_W-1:0]  alloc_value;
    logic [bsc_pkg::FIELD_W-1:0]  total_value;
  } bsc_item_t;

  typedef struct packed {
    logic                        deadlock;
    logic [bsc_pkg::COUNT_W-1:0] finished_count;
  } verdict_t;

  localparam int ITEM_W = $bits(bsc_item_t);

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bsc_item_if   item_ch ();
  bsc_result_if verdict_ch ();

  bankers_safety_check_core dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (verdict_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [bsc_pkg::FIELD_W-1:0] claim_mem [N_PROCS*N_RES];
  logic [bsc_pkg::FIELD_W-1:0] alloc_mem [N_PROCS*N_RES];
  logic [bsc_pkg::FIELD_W-1:0] total_mem [N_RES];
  bit                          claim_written [N_PROCS*N_RES];
  bit                          total_written [N_RES];
  logic [bsc_pkg::COUNT_W-1:0] cfg_procs = 5'd1;
  logic [bsc_pkg::COUNT_W-1:0] cfg_res = 5'd1;

  verdict_t pending_verdicts [$];
  int fail_count = 0;
  int accepted_items = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int eff_procs();
    return (cfg_procs > N_PROCS) ? N_PROCS : int'(cfg_procs);
  endfunction

  function automatic int eff_res();
    return (cfg_res > N_RES) ? N_RES : int'(cfg_res);
  endfunction

  function automatic logic [bsc_pkg::FIELD_W-1:0] clip16(input int v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic verdict_t safety_verdict();
    verdict_t                v;
    logic signed [21:0]      avail [N_RES];
    logic signed [21:0]      need;
    logic [N_PROCS-1:0]      done;
    int                      np;
    int                      nr;
    int                      finished;
    bit                      progress;
    bit                      fits;
    np = eff_procs();
    nr = eff_res();
    for (int j = 0; j < nr; j++) begin
      avail[j] = $signed({6'b0, total_mem[j]});
      for (int i = 0; i < np; i++)
        avail[j] = avail[j] - $signed({6'b0, alloc_mem[i*N_RES+j]});
    end
    done = '0;
    finished = 0;
    while (finished < np) begin
      progress = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++) begin
            need = $signed({6'b0, claim_mem[i*N_RES+j]})
                 - $signed({6'b0, alloc_mem[i*N_RES+j]});
            if (need > avail[j]) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < nr; j++)
              avail[j] = avail[j] + $signed({6'b0, alloc_mem[i*N_RES+j]});
            done[i] = 1'b1;
            progress = 1'b1;
            finished++;
          end
        end
      end
      if (!progress) break;
    end
    v.deadlock = (finished < np);
    v.finished_count = finished[bsc_pkg::COUNT_W-1:0];
    return v;
  endfunction

  function automatic void record_item(input bsc_item_t it);
    int idx;
    idx = int'({it.proc_index, it.res_index});
    case (it.opcode)
      bsc_pkg::OP_LOAD_CLAIM: begin
        claim_mem[idx] = it.max_value;
        alloc_mem[idx] = it.alloc_value;
        claim_written[idx] = 1'b1;
        accepted_items++;
      end
      bsc_pkg::OP_LOAD_TOTAL: begin
        total_mem[it.res_index] = it.total_value;
        total_written[it.res_index] = 1'b1;
        accepted_items++;
      end
      bsc_pkg::OP_CHECK: begin
        pending_verdicts.push_back(safety_verdict());
        accepted_items++;
      end
      default: ;
    endcase
  endfunction

  function automatic bsc_item_t claim_item(input int pi, input int ri,
                                           input logic [bsc_pkg::FIELD_W-1:0] maxv,
                                           input logic [bsc_pkg::FIELD_W-1:0] allocv);
    bsc_item_t it;
    it.opcode = bsc_pkg::OP_LOAD_CLAIM;
    it.proc_index = pi[3:0];
    it.res_index = ri[3:0];
    it.max_value = maxv;
    it.alloc_value = allocv;
    it.total_value = bsc_pkg::FIELD_W'($urandom());
    return it;
  endfunction

  function automatic bsc_item_t total_item(input int ri,
                                           input logic [bsc_pkg::FIELD_W-1:0] tv);
    bsc_item_t it;
    it.opcode = bsc_pkg::OP_LOAD_TOTAL;
    it.proc_index = bsc_pkg::INDEX_W'($urandom());
    it.res_index = ri[3:0];
    it.max_value = bsc_pkg::FIELD_W'($urandom());
    it.alloc_value = bsc_pkg::FIELD_W'($urandom());
    it.total_value = tv;
    return it;
  endfunction

  function automatic bsc_item_t noise_item();
    bsc_item_t it;
    it = ITEM_W'({$urandom(), $urandom()});
    case ($urandom_range(2))
      0: it.opcode = bsc_pkg::OP_LOAD_CLAIM;
      1: it.opcode = bsc_pkg::OP_LOAD_TOTAL;
      default: it.opcode = OP_UNUSED;
    endcase
    return it;
  endfunction

  task automatic send_item(input bsc_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.opcode      <= it.opcode;
    item_ch.proc_index  <= it.proc_index;
    item_ch.res_index   <= it.res_index;
    item_ch.max_value   <= it.max_value;
    item_ch.alloc_value <= it.alloc_value;
    item_ch.total_value <= it.total_value;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    record_item(it);
  endtask

  // entries in use must be loaded before a check reads them
  task automatic send_check();
    bsc_item_t it;
    for (int i = 0; i < eff_procs(); i++)
      for (int j = 0; j < eff_res(); j++)
        if (!claim_written[i*N_RES+j])
          send_item(claim_item(i, j, bsc_pkg::FIELD_W'($urandom()),
                               bsc_pkg::FIELD_W'($urandom())));
    for (int j = 0; j < eff_res(); j++)
      if (!total_written[j]) send_item(total_item(j, bsc_pkg::FIELD_W'($urandom())));
    it = ITEM_W'({$urandom(), $urandom()});
    it.opcode = bsc_pkg::OP_CHECK;
    send_item(it);
  endtask

  task automatic drain_to_idle();
    item_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [bsc_pkg::COUNT_W-1:0] value);
    logic [31:0] wd;
    wd = $urandom();
    wd[bsc_pkg::COUNT_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == bsc_pkg::REG_PROC_COUNT) cfg_procs = value;
    else cfg_res = value;
    @(posedge clk);
  endtask

  task automatic set_counts(input int p, input int r);
    apb_write(bsc_pkg::REG_PROC_COUNT, p[bsc_pkg::COUNT_W-1:0]);
    apb_write(bsc_pkg::REG_RES_COUNT, r[bsc_pkg::COUNT_W-1:0]);
  endtask

  // random claims with need and slack on a common scale, totals around the column sums
  task automatic run_scenario(input int scale);
    int np;
    int nr;
    int a;
    int need;
    int tv;
    int colsum [N_RES];
    np = eff_procs();
    nr = eff_res();
    for (int j = 0; j < N_RES; j++) colsum[j] = 0;
    for (int i = 0; i < np; i++)
      for (int j = 0; j < nr; j++) begin
        a = int'($urandom_range(0, scale));
        need = int'($urandom_range(0, scale));
        send_item(claim_item(i, j, clip16(a + need), a[15:0]));
        colsum[j] += a;
      end
    for (int j = 0; j < nr; j++) begin
      if ($urandom_range(7) == 0) tv = int'($urandom_range(0, clip16(colsum[j])));
      else tv = colsum[j] + int'($urandom_range(0, scale));
      send_item(total_item(j, clip16(tv)));
    end
    send_check();
    if ($urandom_range(1) == 1 && np > 0 && nr > 0) begin
      send_item(claim_item(int'($urandom_range(0, np - 1)), int'($urandom_range(0, nr - 1)),
                           bsc_pkg::FIELD_W'($urandom_range(0, scale)),
                           bsc_pkg::FIELD_W'($urandom_range(0, scale))));
      send_check();
    end
  endtask

  task automatic test_directed_cases();
    send_item(claim_item(0, 0, 16'd5, 16'd2));
    send_item(total_item(0, 16'd3));
    send_check();
    send_item(total_item(0, 16'd5));
    send_check();
    send_item('{opcode: OP_UNUSED, proc_index: 4'hF, res_index: 4'hF, max_value: 16'hFFFF,
                alloc_value: 16'hFFFF, total_value: 16'hFFFF});
    send_item(claim_item(0, 0, 16'hFFFF, 16'h0000));
    send_item(total_item(0, 16'hFFFF));
    send_check();
    // negative available with negative need
    send_item(claim_item(0, 0, 16'h0000, 16'hFFFF));
    send_item(total_item(0, 16'h0000));
    send_check();
    drain_to_idle();
    set_counts(2, 2);
    send_item(claim_item(0, 0, 16'd4, 16'd1));
    send_item(claim_item(0, 1, 16'd2, 16'd1));
    send_item(claim_item(1, 0, 16'd2, 16'd1));
    send_item(claim_item(1, 1, 16'd1, 16'd0));
    send_item(total_item(0, 16'd3));
    send_item(total_item(1, 16'd2));
    send_check();
    drain_to_idle();
    set_counts(0, 2);
    send_check();
    drain_to_idle();
    set_counts(2, 0);
    send_check();
    drain_to_idle();
  endtask

  task automatic test_result_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    set_counts(2, 2);
    hold_left = 2000;
    repeat (6) begin
      send_item(claim_item(int'($urandom_range(0, 1)), int'($urandom_range(0, 1)),
                           bsc_pkg::FIELD_W'($urandom_range(0, 8)),
                           bsc_pkg::FIELD_W'($urandom_range(0, 4))));
      send_check();
    end
    drain_to_idle();
  endtask

  task automatic test_full_size();
    set_counts(16, 16);
    // each process waits for the release of the next one: one finish per pass
    for (int i = 0; i < N_PROCS; i++)
      for (int j = 0; j < N_RES; j++)
        if (j == 0) send_item(claim_item(i, j, bsc_pkg::FIELD_W'(16 - i), 16'd1));
        else send_item(claim_item(i, j, 16'd0, 16'd0));
    send_item(total_item(0, 16'd16));
    for (int j = 1; j < N_RES; j++) send_item(total_item(j, 16'd0));
    send_check();
    drain_to_idle();
    set_counts(20, 31);
    run_scenario(65535);
    drain_to_idle();
  endtask

  task automatic test_random_traffic();
    int phase;
    int start;
    int p;
    int r;
    int scale;
    phase = 0;
    start = accepted_items;
    while (accepted_items - start < RANDOM_ITEMS) begin
      drain_to_idle();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case ($urandom_range(9))
        0: begin p = 0; r = int'($urandom_range(1, 4)); end
        1: begin p = int'($urandom_range(1, 4)); r = 0; end
        2: begin p = int'($urandom_range(17, 31)); r = int'($urandom_range(1, 2)); end
        3: begin p = int'($urandom_range(1, 2)); r = int'($urandom_range(17, 31)); end
        default: begin p = int'($urandom_range(1, 5)); r = int'($urandom_range(1, 5)); end
      endcase
      set_counts(p, r);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(4) != 0) begin
          case ($urandom_range(3))
            0: scale = 3;
            1: scale = 20;
            2: scale = 1000;
            default: scale = 65535;
          endcase
          run_scenario(scale);
        end else begin
          repeat ($urandom_range(1, 6)) send_item(noise_item());
          send_check();
        end
      end
      phase++;
    end
    drain_to_idle();
  endtask

  initial begin
    verdict_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        verdict_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected transaction: deadlock %0b finished_count %0d",
               verdict_ch.deadlock, verdict_ch.finished_count);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_ch.deadlock !== want.deadlock) begin
          $error("deadlock: expected %0b, got %0b", want.deadlock, verdict_ch.deadlock);
          fail_count++;
        end
        if (verdict_ch.finished_count !== want.finished_count) begin
          $error("finished_count: expected %0d, got %0d",
                 want.finished_count, verdict_ch.finished_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bankers_safety_check_core_tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.opcode = bsc_pkg::OP_LOAD_CLAIM;
    item_ch.proc_index = '0;
    item_ch.res_index = '0;
    item_ch.max_value = '0;
    item_ch.alloc_value = '0;
    item_ch.total_value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_result_backpressure();
    test_full_size();
    test_random_traffic();
    if (fail_count == 0) begin
      $display("bankers_safety_check_core_tb: PASS");
    end else begin
      $display("bankers_safety_check_core_tb: FAIL");
    end
    $finish;
  end

endmodule
